// ----- rtl/mima_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI input message assembler package
// Shared types and constants for the per-device MIDI byte parser.
// ----------------------------------------------------------------------------
package mima_pkg;

    // Largest device count that the enable register can describe.
    localparam int unsigned MAX_DEVICES = 8;

    localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
    localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
    localparam logic [3:0] MIDI_SYS_NIBBLE  = 4'hF;
    localparam logic [3:0] MIDI_PROG_NIBBLE = 4'hC;
    localparam logic [3:0] MIDI_PRES_NIBBLE = 4'hD;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    localparam logic [15:0] SYSEX_LEN_RESET = 16'd256;

    // Register numbers, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_ACTIVE_DEVICES = 2'd0,
        REG_DEVICE_ENABLE  = 2'd1,
        REG_SYSEX_LENGTH   = 2'd2,
        REG_UNUSED         = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [3:0]  active_devices;
        logic [7:0]  device_enable;
        logic [15:0] sysex_buffer_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  dev_id;
        logic [7:0]  midi_byte;
        logic [31:0] timestamp;
        logic        buffer_available;
    } t_item;

    typedef struct packed {
        logic        in_sysex;
        logic [1:0]  partial_count;
        logic [23:0] partial_bytes;
        logic [7:0]  running_status;
        logic [15:0] sysex_fill;
    } t_dev_state;

    typedef struct packed {
        logic [2:0]  out_dev;
        logic        kind;
        logic [23:0] short_message;
        logic [7:0]  sysex_byte;
        logic [15:0] byte_index;
        logic        buffer_done;
        logic [31:0] event_time;
    } t_result;

endpackage

// ----- rtl/mima_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI input message assembler channels
// Valid/ready channels for received bytes and for assembled results.
// ----------------------------------------------------------------------------
interface mima_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  dev_id;
    logic [7:0]  midi_byte;
    logic [31:0] timestamp;
    logic        buffer_available;

    modport source (output valid, dev_id, midi_byte, timestamp, buffer_available,
                    input ready);
    modport sink   (input valid, dev_id, midi_byte, timestamp, buffer_available,
                    output ready);
endinterface

interface mima_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_dev;
    logic        kind;
    logic [23:0] short_message;
    logic [7:0]  sysex_byte;
    logic [15:0] byte_index;
    logic        buffer_done;
    logic [31:0] event_time;

    modport source (output valid, out_dev, kind, short_message, sysex_byte,
                    byte_index, buffer_done, event_time, input ready);
    modport sink   (input valid, out_dev, kind, short_message, sysex_byte,
                    byte_index, buffer_done, event_time, output ready);
endinterface

// ----- rtl/midi_input_message_assembler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI input message assembler
// Per-device running-status parser turning raw MIDI bytes into short
// messages and system-exclusive buffer writes.
// ----------------------------------------------------------------------------
// Usage. Received bytes enter on the request channel i_in, each tagged with
// its device number, a timestamp and a flag saying whether the host has a
// system-exclusive buffer queued. Results leave on o_out: either a complete
// short message, or one system-exclusive byte with its buffer position and a
// flag set when the buffer is complete. A byte that completes nothing, or
// belongs to a device beyond active_devices or without its enable bit, gives
// no result. The APB port sets the device count, the enables and the buffer
// length; the user must write it only while the block is idle (unchecked).
// Results are registered: the byte in the input register is parsed there and
// its result enters the output register once free. One request is taken in
// every cycle while the output does not stall: the per-device state is read
// and written back in the same cycle that the input register's byte is
// parsed, so consecutive bytes for one device follow each other without a gap.
// When the receiver stalls, the waiting result holds in the output register
// and one further request is taken into the input register; then i_in.ready
// falls, if that byte has a result, until the output moves. Reset clears
// the configuration and every device's parsing state, buffer length 256 bytes.
// ----------------------------------------------------------------------------
module midi_input_message_assembler
    import mima_pkg::*;
#(
    parameter int unsigned NUM_DEVICES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mima_in_if.sink     i_in,
    mima_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Only devices that the enable register can describe get storage.
    localparam int unsigned DEPTH = (NUM_DEVICES < MAX_DEVICES) ? NUM_DEVICES
                                                                : MAX_DEVICES;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [7:0]  DEV_LIMIT = 8'(DEPTH);

    t_cfg        cfg;
    t_item       r_in;
    logic        r_in_valid;
    t_dev_state  r_state [DEPTH];
    t_result     r_out;
    logic        r_out_valid;

    logic [IDX_W-1:0] idx;
    logic             dev_ok;
    t_dev_state       cur_state;
    t_dev_state       n_state;
    logic             res_valid;
    t_result          res;
    logic             out_free;
    logic             advance;

    mima_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A byte counts only for a present device whose enable bit is set.
    assign idx    = r_in.dev_id[IDX_W-1:0];
    assign dev_ok = (r_in.dev_id < {4'd0, cfg.active_devices})
                    && (r_in.dev_id < DEV_LIMIT)
                    && cfg.device_enable[r_in.dev_id[2:0]];
    assign cur_state = r_state[idx];

    mima_parse u_parse (
        .i_item      (r_in),
        .i_state     (cur_state),
        .i_sysex_len (cfg.sysex_buffer_length),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The byte in the input register leaves when it makes no result, or
    // when the output register is free to take its result.
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!(res_valid && dev_ok) || out_free);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in.dev_id           <= i_in.dev_id;
            r_in.midi_byte        <= i_in.midi_byte;
            r_in.timestamp        <= i_in.timestamp;
            r_in.buffer_available <= i_in.buffer_available;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_state[i] <= '0;
            end
        end else if (advance && dev_ok) begin
            r_state[idx] <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && dev_ok && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dev_ok && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_dev       = r_out.out_dev;
    assign o_out.kind          = r_out.kind;
    assign o_out.short_message = r_out.short_message;
    assign o_out.sysex_byte    = r_out.sysex_byte;
    assign o_out.byte_index    = r_out.byte_index;
    assign o_out.buffer_done   = r_out.buffer_done;
    assign o_out.event_time    = r_out.event_time;

endmodule

// ----- rtl/mima_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI input message assembler configuration registers
// APB-style register file holding device count, enables and buffer length.
// ----------------------------------------------------------------------------
module mima_cfg
    import mima_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    t_reg_index sel;

    assign sel    = t_reg_index'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_devices      <= 4'd0;
            r_cfg.device_enable       <= 8'd0;
            r_cfg.sysex_buffer_length <= SYSEX_LEN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (sel)
                REG_ACTIVE_DEVICES: r_cfg.active_devices      <= pwdata[3:0];
                REG_DEVICE_ENABLE:  r_cfg.device_enable       <= pwdata[7:0];
                REG_SYSEX_LENGTH:   r_cfg.sysex_buffer_length <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_ACTIVE_DEVICES: prdata = {28'd0, r_cfg.active_devices};
            REG_DEVICE_ENABLE:  prdata = {24'd0, r_cfg.device_enable};
            REG_SYSEX_LENGTH:   prdata = {16'd0, r_cfg.sysex_buffer_length};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/mima_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI input message assembler byte parser
// Given one byte and its device's state, gives the new state and any result.
// ----------------------------------------------------------------------------
module mima_parse
    import mima_pkg::*;
(
    input  t_item      i_item,
    input  t_dev_state i_state,
    input  logic [15:0] i_sysex_len,
    output t_dev_state o_state,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [7:0]  v;
    logic        sysex_sel;
    logic [16:0] next_fill;
    logic        sx_done;
    logic [1:0]  cnt_in;
    logic [1:0]  cnt_new;
    logic [23:0] bytes;
    logic [23:0] merged;
    logic [7:0]  st;
    logic [1:0]  need;
    logic        rs_usable;
    logic        orphan;
    logic [23:0] mask;

    assign v         = i_item.midi_byte;
    assign sysex_sel = (v == MIDI_SYSEX_START) || i_state.in_sysex;
    assign next_fill = {1'b0, i_state.sysex_fill} + 17'd1;
    assign rs_usable = i_state.running_status[7]
                       && (i_state.running_status[7:4] != MIDI_SYS_NIBBLE);
    assign orphan    = !v[7] && (i_state.partial_count == 2'd0) && !rs_usable;

    // Regular path: pick up the running status for a data byte that starts
    // a message, then drop the byte into the next free slot.
    always_comb begin
        if (!v[7] && i_state.partial_count == 2'd0) begin
            bytes  = {16'd0, i_state.running_status};
            cnt_in = 2'd1;
        end else begin
            bytes  = i_state.partial_bytes;
            cnt_in = (i_state.partial_count == 2'd3) ? 2'd2 : i_state.partial_count;
        end
        merged = bytes;
        unique case (cnt_in)
            2'd0:    merged[7:0]   = v;
            2'd1:    merged[15:8]  = v;
            default: merged[23:16] = v;
        endcase
        cnt_new = cnt_in + 2'd1;
        st      = merged[7:0];
        if (st[7:4] == MIDI_PROG_NIBBLE || st[7:4] == MIDI_PRES_NIBBLE) begin
            need = 2'd2;
            mask = 24'h00FFFF;
        end else if (st[7:4] == MIDI_SYS_NIBBLE) begin
            need = 2'd1;
            mask = 24'h0000FF;
        end else begin
            need = 2'd3;
            mask = 24'hFFFFFF;
        end
    end

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        sx_done     = 1'b0;
        o_res.out_dev       = i_item.dev_id[2:0];
        o_res.kind          = KIND_SHORT;
        o_res.short_message = 24'd0;
        o_res.sysex_byte    = 8'd0;
        o_res.byte_index    = 16'd0;
        o_res.buffer_done   = 1'b0;
        o_res.event_time    = i_item.timestamp;

        if (sysex_sel) begin
            o_state.in_sysex      = 1'b1;
            o_state.partial_count = 2'd0;
            if (i_item.buffer_available) begin
                sx_done            = next_fill >= {1'b0, i_sysex_len};
                o_state.sysex_fill = next_fill[15:0];
            end
            if (v == MIDI_SYSEX_END) begin
                o_state.in_sysex = 1'b0;
                sx_done          = 1'b1;
            end
            if (i_item.buffer_available) begin
                if (sx_done) begin
                    o_state.sysex_fill = 16'd0;
                end
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_SYSEX;
                o_res.sysex_byte  = v;
                o_res.byte_index  = i_state.sysex_fill;
                o_res.buffer_done = sx_done;
            end
        end else if (!orphan) begin
            o_state.partial_bytes = merged;
            if (cnt_new == 2'd1 && st[7:4] != MIDI_SYS_NIBBLE) begin
                o_state.running_status = st;
            end
            if (cnt_new == need) begin
                o_state.partial_count = 2'd0;
                o_res_valid           = 1'b1;
                o_res.short_message   = merged & mask;
            end else begin
                o_state.partial_count = cnt_new;
            end
        end
    end

endmodule
